### hdl/lxd_pkg.sv
// Shared types, constants and command/status bundles of the LZSS XOR decompressor.
package lxd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;

  localparam int BYTE_W     = 8;
  localparam int WSTART_W   = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int SIZE_W     = 32;
  localparam int HCNT_W     = 4;
  localparam int FLAG_W     = 9;
  localparam int LEN_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 1'b1;

  localparam logic [BYTE_W-1:0]   XOR_KEY_RST   = 8'h72;
  localparam logic [WSTART_W-1:0] WIN_START_RST = 12'hfee;

  localparam logic [BYTE_W-1:0] CH_THREE = 8'h33;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  localparam logic [LEN_W-1:0] MATCH_MIN = 5'd3;

  typedef enum logic [1:0] {
    MODE_PEND,
    MODE_COMP,
    MODE_STORED,
    MODE_BAD
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BYTE,
    ACT_COPY
  } act_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              end_of_entry;
    logic              status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic decode;
    logic rd;
    logic emit_lit;
    logic emit_copy;
    logic mark;
    logic end_item;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ignore;
    act_t act;
    logic last;
    logic at_limit;
    logic copy_done;
    logic out_free;
    logic item_out;
  } sts_t;

endpackage

### hdl/lxd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lxd_ctrl.sv
// Controller state machine that sequences header, literal, match and marker work.
module lxd_ctrl
  import lxd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LIT,
    S_COPY_RD,
    S_COPY_WR,
    S_MARK
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.ignore) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.decode = 1'b1;
          case (sts.act)
            ACT_BYTE: state_nxt = S_LIT;
            ACT_COPY: state_nxt = S_COPY_RD;
            default: begin
              if (sts.last) begin
                state_nxt = S_MARK;
              end else begin
                cmd.end_item = 1'b1;
                state_nxt    = S_IDLE;
              end
            end
          endcase
        end
      end
      S_LIT: begin
        if (sts.at_limit) begin
          if (sts.last) begin
            state_nxt = S_MARK;
          end else begin
            cmd.end_item = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.emit_lit = 1'b1;
          cmd.end_item = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_COPY_RD: begin
        if (sts.copy_done || sts.at_limit) begin
          if (sts.last && !sts.item_out) begin
            state_nxt = S_MARK;
          end else begin
            cmd.end_item = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          state_nxt     = S_COPY_RD;
        end
      end
      S_MARK: begin
        if (sts.out_free) begin
          cmd.mark     = 1'b1;
          cmd.end_item = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/lxd_datapath.sv
// Datapath: entry state, header decode, history memory and output register.
module lxd_datapath
  import lxd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  localparam logic [HCNT_W-1:0] HDR_LEN    = 4'd8;
  localparam logic [HCNT_W-1:0] HDR_MAGIC0 = 4'd1;
  localparam logic [HCNT_W-1:0] HDR_MAGIC1 = 4'd2;
  localparam logic [HCNT_W-1:0] HDR_MODE   = 4'd3;
  localparam logic [HCNT_W-1:0] HDR_SIZE0  = 4'd4;
  localparam logic [HCNT_W-1:0] HDR_SIZE1  = 4'd5;
  localparam logic [HCNT_W-1:0] HDR_SIZE2  = 4'd6;
  localparam logic [HCNT_W-1:0] HDR_SIZE3  = 4'd7;

  // Configuration.
  logic [BYTE_W-1:0] xor_key_r;
  logic [AW-1:0]     wstart_r;

  // Entry state.
  logic [AW-1:0]     write_pos_r;
  logic [AW-1:0]     entry_start_r;
  logic [AW:0]       fill_r;
  logic [FLAG_W-1:0] flag_r;
  logic [HCNT_W-1:0] hdr_cnt_r;
  mode_t             mode_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] produced_r;
  logic              pend_r;
  logic              finished_r;
  logic              item_out_r;
  logic              out_valid_r;

  // Payload registers.
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic [BYTE_W-1:0] match_low_r;
  logic [AW-1:0]     src_r;
  logic [LEN_W-1:0]  cnt_r;
  logic              hit_r;
  out_t              out_data_r;

  logic [BYTE_W-1:0] pay;
  logic              hdr_done;
  logic              keep;
  logic              at_limit;
  logic              near_limit;
  logic              out_free;
  logic              copy_last;
  act_t              act;
  logic [AW-1:0]     rel;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] copy_byte;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic              wrote;

  assign pay        = byte_r ^ xor_key_r;
  assign hdr_done   = (hdr_cnt_r == HDR_LEN);
  assign keep       = (mode_r == MODE_COMP);
  assign at_limit   = (produced_r >= size_r);
  assign near_limit = (({1'b0, produced_r} + (SIZE_W + 1)'(1)) >= {1'b0, size_r});
  assign out_free   = !out_valid_r || out_ready;
  assign copy_last  = (cnt_r == LEN_W'(1)) || near_limit;
  assign rel        = src_r - entry_start_r;
  assign copy_byte  = hit_r ? rd_data : '0;

  always_comb begin
    act = ACT_NONE;
    if (hdr_done) begin
      case (mode_r)
        MODE_STORED: act = ACT_BYTE;
        MODE_COMP: begin
          if (pend_r) begin
            act = ACT_COPY;
          end else if ((flag_r >> 1) != '0 && flag_r[0]) begin
            act = ACT_BYTE;
          end
        end
        default: act = ACT_NONE;
      endcase
    end
  end

  assign ram_we    = (cmd.emit_lit && keep) || cmd.emit_copy;
  assign ram_wdata = cmd.emit_copy ? copy_byte : pay;
  assign wrote     = ram_we;

  lxd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos_r),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (src_r),
    .rdata (rd_data)
  );

  assign sts.ignore    = finished_r;
  assign sts.act       = act;
  assign sts.last      = last_r;
  assign sts.at_limit  = at_limit;
  assign sts.copy_done = (cnt_r == '0);
  assign sts.out_free  = out_free;
  assign sts.item_out  = item_out_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control and entry state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_key_r     <= XOR_KEY_RST;
      wstart_r      <= AW'(WIN_START_RST);
      write_pos_r   <= AW'(WIN_START_RST);
      entry_start_r <= AW'(WIN_START_RST);
      fill_r        <= '0;
      flag_r        <= '0;
      hdr_cnt_r     <= '0;
      mode_r        <= MODE_PEND;
      size_r        <= '0;
      produced_r    <= '0;
      pend_r        <= 1'b0;
      finished_r    <= 1'b0;
      item_out_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_XOR_KEY:   xor_key_r <= cfg_wdata[BYTE_W-1:0];
          REG_WIN_START: wstart_r  <= AW'(cfg_wdata[WSTART_W-1:0]);
          default: ;
        endcase
      end

      if (cmd.load_item) begin
        item_out_r <= 1'b0;
        if (in_data.first_byte) begin
          write_pos_r   <= wstart_r;
          entry_start_r <= wstart_r;
          fill_r        <= '0;
          flag_r        <= '0;
          hdr_cnt_r     <= '0;
          mode_r        <= MODE_PEND;
          size_r        <= '0;
          produced_r    <= '0;
          pend_r        <= 1'b0;
          finished_r    <= 1'b0;
        end
      end

      if (cmd.decode) begin
        if (!hdr_done) begin
          hdr_cnt_r <= hdr_cnt_r + HCNT_W'(1);
          case (hdr_cnt_r)
            HDR_MAGIC0: if (byte_r != CH_THREE) mode_r <= MODE_BAD;
            HDR_MAGIC1: if (byte_r != CH_SEMI) mode_r <= MODE_BAD;
            HDR_MODE: begin
              if (mode_r != MODE_BAD) begin
                if (byte_r == CH_ONE) begin
                  mode_r <= MODE_COMP;
                end else if (byte_r == CH_ZERO) begin
                  mode_r <= MODE_STORED;
                end else begin
                  mode_r <= MODE_BAD;
                end
              end
            end
            HDR_SIZE0: size_r[7:0]   <= byte_r;
            HDR_SIZE1: size_r[15:8]  <= byte_r;
            HDR_SIZE2: size_r[23:16] <= byte_r;
            HDR_SIZE3: size_r[31:24] <= byte_r;
            default: ;
          endcase
        end else if (mode_r == MODE_COMP) begin
          if (pend_r) begin
            pend_r <= 1'b0;
            flag_r <= flag_r >> 1;
          end else if ((flag_r >> 1) == '0) begin
            flag_r <= {1'b1, pay};
          end else if (flag_r[0]) begin
            flag_r <= flag_r >> 1;
          end else begin
            pend_r <= 1'b1;
          end
        end
      end

      if (cmd.emit_lit || cmd.emit_copy) begin
        produced_r <= produced_r + SIZE_W'(1);
        item_out_r <= 1'b1;
      end

      if (wrote) begin
        write_pos_r <= write_pos_r + AW'(1);
        if (!fill_r[AW]) begin
          fill_r <= fill_r + (AW + 1)'(1);
        end
      end

      if (cmd.end_item) begin
        finished_r <= last_r;
      end

      if (cmd.emit_lit || cmd.emit_copy || cmd.mark) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      byte_r <= in_data.data_byte;
      last_r <= in_data.last_byte;
    end

    if (cmd.decode && hdr_done && mode_r == MODE_COMP) begin
      if (pend_r) begin
        src_r <= AW'({pay[7:4], match_low_r});
        cnt_r <= {1'b0, pay[3:0]} + MATCH_MIN;
      end else if ((flag_r >> 1) != '0 && !flag_r[0]) begin
        match_low_r <= pay;
      end
    end

    // An entry is valid if it lies in the run written since the entry began.
    if (cmd.rd) begin
      hit_r <= fill_r[AW] || ({1'b0, rel} < fill_r);
    end

    if (cmd.emit_copy) begin
      src_r <= src_r + AW'(1);
      cnt_r <= cnt_r - LEN_W'(1);
    end

    if (cmd.emit_lit) begin
      out_data_r.out_byte     <= pay;
      out_data_r.byte_valid   <= 1'b1;
      out_data_r.run_last     <= 1'b1;
      out_data_r.end_of_entry <= last_r;
      out_data_r.status       <= 1'b0;
    end else if (cmd.emit_copy) begin
      out_data_r.out_byte     <= copy_byte;
      out_data_r.byte_valid   <= 1'b1;
      out_data_r.run_last     <= copy_last;
      out_data_r.end_of_entry <= last_r && copy_last;
      out_data_r.status       <= 1'b0;
    end else if (cmd.mark) begin
      out_data_r.out_byte     <= '0;
      out_data_r.byte_valid   <= 1'b0;
      out_data_r.run_last     <= 1'b1;
      out_data_r.end_of_entry <= 1'b1;
      out_data_r.status       <= (mode_r == MODE_PEND) || (mode_r == MODE_BAD);
    end
  end

endmodule

### hdl/lzss_xor_decompressor.sv
// Top level of the LZSS XOR decompressor: controller plus datapath.
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+------------------------------------------
//  input   | in_valid, in_ready, in_data    | data_byte, first_byte, last_byte
//  output  | out_valid, out_ready, out_data | out_byte, byte_valid, run_last,
//          |                                | end_of_entry, status
//  config  | cfg_we, cfg_index, cfg_wdata   | 0: xor_key, 1: window_start
//
// An item that produces no byte (header bytes, flag bytes, the first half of a
// match) passes through the idle and decode states, and a literal or stored byte
// then through the literal state. A match, of up to 18 bytes, passes through a read
// state and then a write state for each copied byte, because each copied byte first
// reads the history memory and then writes it back at the write position, and one
// more read state sees the count run out; an end marker adds the marker state.
// Reset is synchronous and active low; it restores the register defaults and
// starts an entry with an empty history. The history is never swept: a fill
// count measured from the entry's start position marks which entries are live,
// and reads outside that run return zero, so a new entry starts without delay.
// The output register lets the next item be accepted while a result waits;
// a stalled output only holds the controller when it has another result to give.
module lzss_xor_decompressor
  import lxd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller only walks the per-item sequence; all other state lives in the datapath.
  lxd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lxd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/lzss_xor_decompressor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LZSS XOR decompressor with its own decode model.
module lzss_xor_decompressor_tb;
  import lxd_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 10;
  // Covers the longest match and an end marker after it, which bound how long
  // the block may still be busy after the last result has arrived.
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_XOR_KEY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Percentages of cycles in which the sender holds back an item and the
  // receiver refuses a result.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  always #HALF_PERIOD clk = ~clk;

  lzss_xor_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Decode model. It mirrors the register file and the per-entry state of the
  // block, and turns every accepted item into the results it must cause.
  // ---------------------------------------------------------------------------
  logic [7:0]  key_reg;
  logic [11:0] wstart_reg;
  logic [7:0]  hist_mem [WINDOW_DEPTH_DEF];
  logic [11:0] wr_pos;
  // Remaining flag bits sit below a leading one; the group is used up when
  // only that one (or nothing) is left.
  logic [8:0]  flag_bits;
  logic [3:0]  hdr_count;
  mode_t       entry_mode;
  logic [31:0] size_limit;
  logic [31:0] produced;
  logic [7:0]  match_lo;
  logic        match_wait;
  logic        entry_done;

  out_t        step_out [$];   // results of the item being decoded
  out_t        decoded_q [$];  // results still owed by the block, oldest first
  logic [7:0]  entry_bytes [$];  // raw bytes of the entry under construction

  // Every entry starts from a zero history and a fresh header.
  function automatic void open_entry();
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_pos = wstart_reg;
    flag_bits = '0;
    hdr_count = '0;
    entry_mode = MODE_PEND;
    size_limit = '0;
    produced = '0;
    match_lo = '0;
    match_wait = 1'b0;
    entry_done = 1'b0;
  endfunction

  // Produce one data byte unless the header size is already reached. Stored
  // bytes do not go into the history.
  function automatic void put_byte(logic [7:0] value, bit keep);
    out_t r;
    if (produced >= size_limit) return;
    if (keep) begin
      hist_mem[wr_pos] = value;
      wr_pos = wr_pos + 1'b1;
    end
    r = '0;
    r.out_byte = value;
    r.byte_valid = 1'b1;
    step_out.push_back(r);
    produced = produced + 1;
  endfunction

  // The magic is compared without the key, and so is the size.
  function automatic void take_header_byte(logic [3:0] idx, logic [7:0] value);
    if (idx == 1 && value != CH_THREE) begin
      entry_mode = MODE_BAD;
    end else if (idx == 2 && value != CH_SEMI) begin
      entry_mode = MODE_BAD;
    end else if (idx == 3 && entry_mode != MODE_BAD) begin
      if (value == CH_ONE) entry_mode = MODE_COMP;
      else if (value == CH_ZERO) entry_mode = MODE_STORED;
      else entry_mode = MODE_BAD;
    end else if (idx >= 4 && idx <= 7) begin
      size_limit = size_limit | (32'(value) << (8 * (idx - 4)));
    end
  endfunction

  // One payload byte of a compressed entry, already unkeyed.
  function automatic void lzss_token_byte(logic [7:0] p);
    logic [11:0] rd_pos;
    int unsigned run_len;
    if (match_wait) begin
      // Second half of a match: high nibble of the offset and the length.
      rd_pos = {p[7:4], match_lo};
      run_len = p[3:0] + 3;
      match_wait = 1'b0;
      // Byte by byte, so a copy may read what it has just written.
      for (int i = 0; i < run_len; i++) begin
        put_byte(hist_mem[rd_pos], 1'b1);
        rd_pos = rd_pos + 1'b1;
      end
      flag_bits = flag_bits >> 1;
    end else if (flag_bits[8:1] == 0) begin
      flag_bits = {1'b1, p};
    end else if (flag_bits[0]) begin
      put_byte(p, 1'b1);
      flag_bits = flag_bits >> 1;
    end else begin
      match_lo = p;
      match_wait = 1'b1;
    end
  endfunction

  function automatic void decode_item(in_t item);
    logic [7:0] plain;
    out_t tail;
    step_out.delete();
    if (item.first_byte) open_entry();
    else if (entry_done) return;
    plain = item.data_byte ^ key_reg;
    if (hdr_count < 8) begin
      take_header_byte(hdr_count, item.data_byte);
      hdr_count = hdr_count + 1'b1;
    end else if (entry_mode == MODE_STORED) begin
      put_byte(plain, 1'b0);
    end else if (entry_mode == MODE_COMP) begin
      lzss_token_byte(plain);
    end
    if (item.last_byte) begin
      // With no data from the closing item, a bare marker ends the entry.
      if (step_out.size() == 0) begin
        tail = '0;
        step_out.push_back(tail);
      end
      tail = step_out.pop_back();
      tail.end_of_entry = 1'b1;
      tail.status = (entry_mode == MODE_PEND) || (entry_mode == MODE_BAD);
      step_out.push_back(tail);
      entry_done = 1'b1;
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.run_last = 1'b1;
      step_out.push_back(tail);
    end
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every result taken from the block is matched against the
  // oldest decoded result, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result 0x%03h arrived with nothing expected", out_data);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("byte_valid", want.byte_valid, out_data.byte_valid);
        check_field("run_last", want.run_last, out_data.run_last);
        check_field("end_of_entry", want.end_of_entry, out_data.end_of_entry);
        check_field("status", want.status, out_data.status);
      end
    end
  end

  // The receiver decides at every falling edge whether it takes a result.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Sending. Valid rises at a falling edge and stays up, with the same item,
  // until the block takes it at a rising edge. Valid is only lowered when the
  // sender idles or a phase ends, so it never drops and rises in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_item(item);
  endtask

  task automatic send_entry(bit with_first, bit with_last);
    in_t item;
    foreach (entry_bytes[i]) begin
      item.data_byte = entry_bytes[i];
      item.first_byte = with_first && (i == 0);
      item.last_byte = with_last && (i == entry_bytes.size() - 1);
      send_item(item);
    end
  endtask

  // Quiet point: every owed result has come and the block has had time to
  // finish items that give no result.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    // The key applies at once; the window start only at the next entry,
    // which the model takes care of by loading it in open_entry.
    if (idx == REG_XOR_KEY) key_reg = value[7:0];
    else wstart_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Entry construction. Header bytes go out raw, payload bytes are keyed with
  // the current key so that the block sees the intended plain byte.
  // ---------------------------------------------------------------------------
  function automatic void start_header(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                       logic [31:0] size);
    entry_bytes.delete();
    entry_bytes.push_back(8'($urandom_range(255)));
    entry_bytes.push_back(c1);
    entry_bytes.push_back(c2);
    entry_bytes.push_back(c3);
    for (int k = 0; k < 4; k++) entry_bytes.push_back(size[8*k +: 8]);
  endfunction

  function automatic void trim_entry(int keep_len);
    while (entry_bytes.size() > keep_len) void'(entry_bytes.pop_back());
  endfunction

  function automatic void add_payload(logic [7:0] plain);
    entry_bytes.push_back(plain ^ key_reg);
  endfunction

  function automatic void add_match(logic [11:0] offset, logic [3:0] len_code);
    add_payload(offset[7:0]);
    add_payload({offset[11:8], len_code});
  endfunction

  // Half of the matches point into the part of the window this entry has
  // just filled, the rest anywhere (mostly still zero).
  function automatic logic [11:0] pick_offset();
    if ($urandom_range(1)) return wstart_reg + 12'($urandom_range(63));
    return 12'($urandom);
  endfunction

  function automatic void add_token_groups(int groups);
    logic [7:0] flags;
    for (int g = 0; g < groups; g++) begin
      flags = 8'($urandom);
      add_payload(flags);
      for (int b = 0; b < 8; b++) begin
        if (flags[b]) add_payload(8'($urandom));
        else add_match(pick_offset(), 4'($urandom));
      end
    end
  endfunction

  // Sizes range from empty, through sizes that cut the output, to the
  // largest ones, so that every size bit is seen both ways.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(3))
      0: return 32'($urandom_range(8));
      1: return 32'($urandom_range(8, 48));
      2: return $urandom;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A stored entry sent right after reset without first_byte, so it runs in
  // the entry that reset opened, with the reset key. Its last payload byte is
  // past the size. A byte after the end of the entry must be ignored.
  task automatic test_stored_after_reset();
    in_t stray;
    start_header(CH_THREE, CH_SEMI, CH_ZERO, 32'd2);
    add_payload(8'h00);
    add_payload(8'hff);
    add_payload(8'h5a);
    send_entry(1'b0, 1'b1);
    stray = '0;
    stray.data_byte = 8'ha5;
    stray.last_byte = 1'b1;
    send_item(stray);
  endtask

  // Literals at both extremes, the longest match overlapping the bytes it
  // copies, the shortest match cut by the size, and a trailing half match.
  task automatic test_compressed_tokens();
    start_header(CH_THREE, CH_SEMI, CH_ONE, 32'd22);
    add_payload(8'b0000_0011);
    add_payload(8'h00);
    add_payload(8'hff);
    add_match(wstart_reg, 4'hf);
    add_match(12'hfff, 4'h0);
    add_payload(8'h12);
    send_entry(1'b1, 1'b1);
  endtask

  // Header trouble: an entry ending before the mode byte, a bad mode byte,
  // one ending within the size bytes, and a compressed entry ending on its
  // first flag byte.
  task automatic test_header_errors();
    start_header(CH_THREE, CH_SEMI, CH_ONE, 32'd0);
    trim_entry(3);
    send_entry(1'b1, 1'b1);
    start_header(CH_THREE, CH_SEMI, 8'h32, 32'd1);
    trim_entry(4);
    send_entry(1'b1, 1'b1);
    start_header(CH_THREE, CH_SEMI, CH_ZERO, 32'd5);
    trim_entry(6);
    send_entry(1'b1, 1'b1);
    start_header(CH_THREE, CH_SEMI, CH_ONE, 32'd4);
    add_payload(8'h00);
    send_entry(1'b1, 1'b1);
  endtask

  // Mostly well-formed entries with random content, mixed with broken,
  // short and abandoned entries and stray bytes without first_byte.
  task automatic test_random_entries(int target);
    int counted;
    int kind;
    int keep_len;
    logic [7:0] magic [3];
    counted = 0;
    while (counted < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        start_header(CH_THREE, CH_SEMI, CH_ONE, pick_size());
        add_token_groups($urandom_range(1, 2));
        // A cut entry may end on a flag byte or inside a match.
        if ($urandom_range(3) == 0) begin
          keep_len = $urandom_range(9, entry_bytes.size());
          trim_entry(keep_len);
        end
        send_entry(1'b1, 1'b1);
      end else if (kind < 75) begin
        start_header(CH_THREE, CH_SEMI, CH_ZERO, pick_size());
        repeat ($urandom_range(1, 10)) add_payload(8'($urandom));
        send_entry(1'b1, 1'b1);
      end else if (kind < 85) begin
        magic[0] = CH_THREE;
        magic[1] = CH_SEMI;
        magic[2] = $urandom_range(1) ? CH_ONE : CH_ZERO;
        magic[$urandom_range(2)] = 8'($urandom);
        start_header(magic[0], magic[1], magic[2], pick_size());
        repeat ($urandom_range(0, 4)) add_payload(8'($urandom));
        send_entry(1'b1, 1'b1);
      end else if (kind < 92) begin
        start_header(CH_THREE, CH_SEMI, $urandom_range(1) ? CH_ONE : CH_ZERO, pick_size());
        keep_len = $urandom_range(1, 8);
        trim_entry(keep_len);
        send_entry(1'b1, 1'b1);
      end else if (kind < 96) begin
        // No last byte: the next first_byte drops this entry silently.
        start_header(CH_THREE, CH_SEMI, CH_ONE, pick_size());
        add_token_groups(1);
        keep_len = $urandom_range(1, entry_bytes.size());
        trim_entry(keep_len);
        send_entry(1'b1, 1'b0);
      end else begin
        // Stray bytes: ignored after an ended entry, or they extend one that
        // was left open.
        entry_bytes.delete();
        repeat ($urandom_range(1, 3)) entry_bytes.push_back(8'($urandom));
        send_entry(1'b0, 1'($urandom_range(1)));
      end
      if (kind < 96) counted += entry_bytes.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests with the reset register values, then
  // random entries under several register settings and idling patterns.
  // ---------------------------------------------------------------------------
  initial begin
    key_reg = XOR_KEY_RST;
    wstart_reg = WIN_START_RST;
    open_entry();
    send_idle_pct = 10;
    recv_stall_pct = 72;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_stored_after_reset();
    test_compressed_tokens();
    test_header_errors();

    set_reg(REG_XOR_KEY, 12'h000);
    set_reg(REG_WIN_START, 12'h000);
    test_random_entries(30);

    set_reg(REG_XOR_KEY, 12'h0ff);
    set_reg(REG_WIN_START, 12'hfff);
    send_idle_pct = 72;
    recv_stall_pct = 10;
    test_random_entries(30);

    set_reg(REG_XOR_KEY, 12'($urandom_range(255)));
    set_reg(REG_WIN_START, 12'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_entries(25);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("lzss_xor_decompressor_tb passed");
    end else begin
      $display("lzss_xor_decompressor_tb failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lzss_xor_decompressor_tb failed");
    $finish;
  end

endmodule
